[design/xs32ud_pkg.sv]
// Shared types and constants for the xorshift32 uniform draw block.
// Used by xs32ud_ctrl, xs32ud_dpath and xorshift32_uniform_draw_top.
`timescale 1ns / 1ps

package xs32ud_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned SHIFT_A    = 13;
  localparam int unsigned SHIFT_B    = 17;
  localparam int unsigned SHIFT_C    = 15;
  localparam int unsigned DIV_CNT_W  = 5;   // one quotient bit per cycle; counts the remainder steps of a division
  localparam int unsigned TRY_CNT_W  = 6;   // up to 64 generator steps per draw

  localparam logic [WORD_W-1:0] SEED_RESET = 32'h796C694C;
  localparam logic [WORD_W-1:0] ALL_ONES   = 32'hFFFFFFFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_LIMIT,
    S_DRAW,
    S_MOD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;     // latch request, set up limit division
    logic div_step;    // one remainder step
    logic gen_step;    // advance generator, set up word division
    logic load_limit;  // keep remainder as reject limit
    logic out_load;    // load output register
  } cmd_t;

  typedef struct packed {
    logic start_uniform;  // incoming request needs the rejection loop
    logic div_last;       // last remainder step this cycle
    logic draw_stop;      // generated word accepted or try cap reached
    logic out_free;       // output register can take a new value
  } status_t;

  function automatic logic [WORD_W-1:0] xs_next(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    a = x ^ (x << SHIFT_A);
    b = a ^ (a << SHIFT_B);
    return b ^ (b >> SHIFT_C);
  endfunction

endpackage

[design/xs32ud_ctrl.sv]
// Controller state machine for the xorshift32 uniform draw block.
// Depends on xs32ud_pkg; drives the command struct of xs32ud_dpath.
`timescale 1ns / 1ps

module xs32ud_ctrl
  import xs32ud_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = status.start_uniform ? S_LIMIT : S_STEP;
        end
      end
      S_STEP: begin
        cmd.gen_step = 1'b1;
        state_next   = S_DONE;
      end
      S_LIMIT: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          cmd.load_limit = 1'b1;
          state_next     = S_DRAW;
        end
      end
      S_DRAW: begin
        cmd.gen_step = 1'b1;
        if (status.draw_stop) begin
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[design/xs32ud_dpath.sv]
// Datapath: generator state, bit-serial remainder unit, limit and output registers.
// Depends on xs32ud_pkg; commanded by xs32ud_ctrl.
`timescale 1ns / 1ps

module xs32ud_dpath
  import xs32ud_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              seed_wr_en,
  input  logic [WORD_W-1:0] seed_wr_data,
  input  logic              in_opcode,
  input  logic [WORD_W-1:0] in_low,
  input  logic [WORD_W-1:0] in_high,
  input  cmd_t              cmd,
  output status_t           status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_data
);

  logic [WORD_W-1:0]    gen_state;
  logic [WORD_W-1:0]    gen_next;
  logic [WORD_W-1:0]    word;
  logic [WORD_W-1:0]    low;
  logic [WORD_W-1:0]    range;
  logic [WORD_W-1:0]    limit;
  logic                 uniform;
  logic [WORD_W-1:0]    rem;
  logic [WORD_W-1:0]    rem_next;
  logic [WORD_W-1:0]    dvd;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [TRY_CNT_W-1:0] tries;
  logic [WORD_W:0]      trial;
  logic [WORD_W:0]      diff;
  logic [WORD_W-1:0]    in_range;

  assign gen_next = xs_next(gen_state);
  assign in_range = in_high - in_low + WORD_W'(1);

  assign trial    = {rem, dvd[WORD_W-1]};
  assign diff     = trial - {1'b0, range};
  assign rem_next = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= SEED_RESET;
    end else if (seed_wr_en) begin
      gen_state <= seed_wr_data;
    end else if (cmd.gen_step) begin
      gen_state <= gen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      low     <= in_low;
      range   <= in_range;
      uniform <= in_opcode & (in_range != '0);
      rem     <= '0;
      dvd     <= ALL_ONES;
      div_cnt <= '0;
      tries   <= '0;
    end else begin
      if (cmd.gen_step) begin
        word    <= gen_next;
        tries   <= tries + TRY_CNT_W'(1);
        rem     <= '0;
        dvd     <= gen_next;
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        rem     <= rem_next;
        dvd     <= dvd << 1;
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      if (cmd.load_limit) begin
        limit <= rem_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= uniform ? rem + low : word;
    end
  end

  assign status.start_uniform = in_opcode & (in_range != '0);
  assign status.div_last      = (div_cnt == '1);
  assign status.draw_stop     = (gen_next > limit) || (tries == '1);
  assign status.out_free      = ~out_valid | out_ready;

endmodule

[design/xorshift32_uniform_draw_top.sv]
// Top level of the xorshift32 uniform draw block.
// Depends on xs32ud_pkg, xs32ud_ctrl and xs32ud_dpath.
//
// Usage:
//   Requests arrive on the s_axis channel: tuser is the opcode (0 raw word,
//   1 uniform draw), tdata holds range_low in bits 31:0, range_high in 63:32.
//   Each request yields one 32-bit result on the m_axis channel.
//   seed_wr_en/seed_wr_data load the generator state; write only while idle.
// Sequence:
//   Raw requests (and uniform requests whose range wraps to zero) are
//   captured, take one generator step and load the result. Uniform requests
//   run the shared bit-serial remainder unit twice (reject limit, then final
//   modulo) with one cycle per generator step between, for 1..64 steps.
//   One request is in work at a time; the next is accepted once the result
//   has been placed in the output register.
// Reset:
//   rst (synchronous) loads the generator with 0x796C694C and empties the
//   output register.
// Stalls:
//   The result holds in the output register while m_axis_tready is low; a
//   following request is taken meanwhile and waits when done.
`timescale 1ns / 1ps

module xorshift32_uniform_draw_top
  import xs32ud_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              seed_wr_en,
  input  logic [WORD_W-1:0] seed_wr_data,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,   // [31:0] range_low, [63:32] range_high
  input  logic              s_axis_tuser,   // [0] opcode
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [WORD_W-1:0] m_axis_tdata    // [31:0] random_value
);

  cmd_t    cmd;
  status_t status;

  xs32ud_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  xs32ud_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .seed_wr_en   (seed_wr_en),
    .seed_wr_data (seed_wr_data),
    .in_opcode    (s_axis_tuser),
    .in_low       (s_axis_tdata[31:0]),
    .in_high      (s_axis_tdata[63:32]),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_data     (m_axis_tdata)
  );

endmodule
